FILE: hw/rtl/dfj_pkg.sv
package dfj_pkg;

   localparam int unsigned QW = 31;
   localparam int unsigned DivSteps = 31;
   localparam int unsigned Latency = 38;
   localparam logic [QW-1:0] OneQ16 = 31'h0001_0000;
   localparam logic [QW-1:0] JumpLimitReset = 31'd65536000;

   typedef enum logic [2:0] {
      REG_DARCY    = 3'd0,
      REG_INERTIAL = 3'd1,
      REG_LENGTH   = 3'd2,
      REG_SIGN     = 3'd3,
      REG_LIMIT    = 3'd4,
      REG_DENSITY  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_NONPOS = 2'd1,
      SIGN_NONNEG = 2'd2,
      SIGN_UNUSED = 2'd3
   } sign_mode_type;

   typedef struct packed {
      logic [QW-1:0] darcy;
      logic [QW-1:0] inertial;
      logic [QW-1:0] length;
      logic [1:0]    sign_mode;
      logic [QW-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic [QW-1:0] veff;
      logic [QW-1:0] deff;
      logic          neg;
      logic          flux_zero;
      logic          area_zero;
   } side_type;

   // unsigned q15.16 product, floor, saturated to 31 bits
   function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
      logic [2*QW-1:0] p;
      p = a * b;
      if (|p[2*QW-1:QW+16]) return '1;
      return p[QW+15:16];
   endfunction

endpackage

FILE: hw/rtl/dfj_div.sv
module dfj_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [31:0]           in_absflux,
   input  logic [dfj_pkg::QW-1:0] in_area,
   input  dfj_pkg::side_type     in_side,
   output logic                  out_valid,
   output logic [dfj_pkg::QW-1:0] out_speed,
   output dfj_pkg::side_type     out_side
);
   import dfj_pkg::*;

   // stage 0 holds the high part of the dividend, stage k+1 resolves quotient bit 30-k
   logic                valid_ff [0:DivSteps];
   logic [QW-1:0]       rem_ff   [0:DivSteps];
   logic [QW-1:0]       quo_ff   [0:DivSteps];
   logic [QW-1:0]       low_ff   [0:DivSteps];
   logic [QW-1:0]       area_ff  [0:DivSteps];
   logic                ovf_ff   [0:DivSteps];
   side_type            side_ff  [0:DivSteps];

   logic [16:0] hi;
   assign hi = in_absflux[31:15];

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else       valid_ff[0] <= in_valid;
      rem_ff[0]  <= {14'd0, hi};
      quo_ff[0]  <= '0;
      low_ff[0]  <= {in_absflux[14:0], 16'd0};
      area_ff[0] <= in_area;
      ovf_ff[0]  <= ({14'd0, hi} >= in_area);
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic [QW:0]   trial;
      logic          fits;
      logic [QW-1:0] rem_in;
      assign trial  = {rem_ff[k], low_ff[k][QW-1-k]};
      assign fits   = (trial >= {1'b0, area_ff[k]});
      assign rem_in = fits ? QW'(trial - {1'b0, area_ff[k]}) : trial[QW-1:0];
      always_ff @(posedge clock) begin
         if (reset) valid_ff[k+1] <= 1'b0;
         else       valid_ff[k+1] <= valid_ff[k];
         rem_ff[k+1]  <= rem_in;
         quo_ff[k+1]  <= {quo_ff[k][QW-2:0], fits};
         low_ff[k+1]  <= low_ff[k];
         area_ff[k+1] <= area_ff[k];
         ovf_ff[k+1]  <= ovf_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = valid_ff[DivSteps];
   assign out_speed = ovf_ff[DivSteps] ? '1 : quo_ff[DivSteps];
   assign out_side  = side_ff[DivSteps];

endmodule

FILE: hw/rtl/dfj_calc.sv
module dfj_calc (
   input  logic                  clock,
   input  logic                  reset,
   input  dfj_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   input  logic [dfj_pkg::QW-1:0] in_speed,
   input  dfj_pkg::side_type     in_side,
   output logic                  out_valid,
   output logic [31:0]           out_jump,
   output logic                  out_flipped,
   output logic                  out_bounded,
   output logic                  out_zero_area
);
   import dfj_pkg::*;

   logic [4:0] valid_ff;
   side_type   s1_ff, s2_ff, s3_ff, s4_ff;
   logic [QW-1:0] a_ff, b_ff, sq_ff, speed_ff;
   logic [QW-1:0] t1_ff, t2_ff, sum_ff, mag_ff;
   logic [31:0] jump_ff;
   logic flip_ff, bound_ff, zero_ff;

   logic [QW:0] sum_wide;
   assign sum_wide = {1'b0, t1_ff} + {1'b0, t2_ff};

   logic signed [32:0] j0, j1, lim;
   logic flip_in, bound_in;
   logic [31:0] jump_in;
   always_comb begin
      lim = $signed({2'b0, cfg.limit});
      if (s4_ff.flux_zero)  j0 = '0;
      else if (s4_ff.neg)   j0 = $signed({2'b0, mag_ff});
      else                  j0 = -$signed({2'b0, mag_ff});
      priority if (cfg.sign_mode == SIGN_NONPOS && j0 > 0) begin
         j1 = -j0;
         flip_in = 1'b1;
      end else if (cfg.sign_mode == SIGN_NONNEG && j0 < 0) begin
         j1 = -j0;
         flip_in = 1'b1;
      end else begin
         j1 = j0;
         flip_in = 1'b0;
      end
      bound_in = 1'b1;
      priority if (j1 > lim)  jump_in = lim[31:0];
      else if (j1 < -lim)     jump_in = 32'(-lim);
      else begin
         jump_in  = j1[31:0];
         bound_in = 1'b0;
      end
      if (s4_ff.area_zero) begin
         jump_in  = '0;
         flip_in  = 1'b0;
         bound_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= {valid_ff[3:0], in_valid};
      a_ff <= qmul(cfg.darcy, in_side.veff);
      b_ff <= qmul(cfg.inertial, in_side.deff);
      sq_ff <= qmul(in_speed, in_speed);
      speed_ff <= in_speed;
      s1_ff <= in_side;
      t1_ff <= qmul(a_ff, speed_ff);
      t2_ff <= qmul(b_ff, sq_ff) >> 1;
      s2_ff <= s1_ff;
      sum_ff <= sum_wide[QW] ? '1 : sum_wide[QW-1:0];
      s3_ff <= s2_ff;
      mag_ff <= qmul(sum_ff, cfg.length);
      s4_ff <= s3_ff;
      jump_ff <= jump_in;
      flip_ff <= flip_in;
      bound_ff <= bound_in;
      zero_ff <= s4_ff.area_zero;
   end

   assign out_valid     = valid_ff[4];
   assign out_jump      = jump_ff;
   assign out_flipped   = flip_ff;
   assign out_bounded   = bound_ff;
   assign out_zero_area = zero_ff;

endmodule

FILE: hw/rtl/darcy_forchheimer_face_jump.sv
// darcy-forchheimer pressure jump, one boundary face per transfer. a face is taken at
// every clock edge with start high; busy is always low, so a new face may follow in every
// cycle. the result appears on rsp_* with rsp_strobe high for exactly one cycle, once the
// face has passed one entry stage, one divider load stage, 31 stages of the restoring
// divider (one quotient bit per stage) and five multiply / sign / clamp stages. the
// receiver cannot stall, so it must take every strobed result. the user must write registers
// through the apb port only while no face is in flight; the block does not enforce this.
module darcy_forchheimer_face_jump (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [31:0]     req_face_flux,
   input  logic [30:0]            req_face_area,
   input  logic [30:0]            req_kinematic_viscosity,
   input  logic [30:0]            req_density,
   output logic                   rsp_strobe,
   output logic signed [31:0]     rsp_pressure_jump,
   output logic                   rsp_sign_flipped,
   output logic                   rsp_magnitude_bounded,
   output logic                   rsp_zero_area,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [4:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import dfj_pkg::*;

   // configuration registers
   logic [QW-1:0] darcy_ff, inertial_ff, length_ff, limit_ff;
   logic [1:0]    sign_ff;
   logic          dens_ff;
   logic          wr;
   reg_index_type widx;
   cfg_type       cfg;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign wr     = psel & penable & pwrite;
   assign widx   = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         darcy_ff <= '0;
         inertial_ff <= '0;
         length_ff <= '0;
         sign_ff <= '0;
         limit_ff <= JumpLimitReset;
         dens_ff <= 1'b0;
      end else if (wr) begin
         unique case (widx)
            REG_DARCY:    darcy_ff <= pwdata[QW-1:0];
            REG_INERTIAL: inertial_ff <= pwdata[QW-1:0];
            REG_LENGTH:   length_ff <= pwdata[QW-1:0];
            REG_SIGN:     sign_ff <= pwdata[1:0];
            REG_LIMIT:    limit_ff <= pwdata[QW-1:0];
            REG_DENSITY:  dens_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (widx)
         REG_DARCY:    prdata = {1'b0, darcy_ff};
         REG_INERTIAL: prdata = {1'b0, inertial_ff};
         REG_LENGTH:   prdata = {1'b0, length_ff};
         REG_SIGN:     prdata = {30'd0, sign_ff};
         REG_LIMIT:    prdata = {1'b0, limit_ff};
         REG_DENSITY:  prdata = {31'd0, dens_ff};
         default:      prdata = '0;
      endcase
   end

   assign cfg = '{darcy: darcy_ff, inertial: inertial_ff, length: length_ff,
                  sign_mode: sign_ff, limit: limit_ff};

   // entry stage: flux magnitude and effective viscosity / density
   logic          e_valid_ff;
   logic [31:0]   e_abs_ff;
   logic [QW-1:0] e_area_ff;
   side_type      e_side_ff;
   logic [31:0]   abs_in;

   // two's complement magnitude, the most negative flux gives 2^31 exactly
   assign abs_in = req_face_flux[31] ? 32'(-req_face_flux) : req_face_flux;

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else       e_valid_ff <= start;
      e_abs_ff  <= abs_in;
      e_area_ff <= req_face_area;
      e_side_ff.veff <= dens_ff ? qmul(req_kinematic_viscosity, req_density)
                                : req_kinematic_viscosity;
      e_side_ff.deff <= dens_ff ? req_density : OneQ16;
      e_side_ff.neg <= req_face_flux[31];
      e_side_ff.flux_zero <= (req_face_flux == '0);
      e_side_ff.area_zero <= (req_face_area == '0);
   end

   // speed = (|flux| << 16) / area, saturated
   logic          d_valid;
   logic [QW-1:0] d_speed;
   side_type      d_side;

   dfj_div u_div (
      .clock(clock), .reset(reset),
      .in_valid(e_valid_ff), .in_absflux(e_abs_ff), .in_area(e_area_ff), .in_side(e_side_ff),
      .out_valid(d_valid), .out_speed(d_speed), .out_side(d_side)
   );

   // resistance terms, length, sign enforcement and clamp
   logic [31:0] jump;
   dfj_calc u_calc (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(d_valid), .in_speed(d_speed), .in_side(d_side),
      .out_valid(rsp_strobe), .out_jump(jump), .out_flipped(rsp_sign_flipped),
      .out_bounded(rsp_magnitude_bounded), .out_zero_area(rsp_zero_area)
   );
   assign rsp_pressure_jump = $signed(jump);

   // a zero area face gives a clean zero with no other flag
   a_zero_area: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_zero_area |->
         rsp_pressure_jump == 0 && !rsp_sign_flipped && !rsp_magnitude_bounded)
      else $error("zero area result not clean");

   // a clamped jump sits exactly on the limit
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_magnitude_bounded |->
         rsp_pressure_jump == $signed({1'b0, limit_ff}) ||
         rsp_pressure_jump == -$signed({1'b0, limit_ff}))
      else $error("clamped jump off the limit");

   // forced nonpositive mode never gives a positive jump
   a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && sign_ff == SIGN_NONPOS |-> rsp_pressure_jump <= 0)
      else $error("sign enforcement missed");

endmodule
